// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers; every use sits in a module with clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ----- rtl/d2q_pkg.sv -----
`timescale 1ns / 1ps
package d2q_pkg;

    localparam int NDIR   = 9;
    localparam int NSTAGE = 9;

    // Pipeline stage positions
    localparam int ST_IN   = 0;
    localparam int ST_MOM  = 1;
    localparam int ST_SQ   = 2;
    localparam int ST_B2   = 3;
    localparam int ST_DA   = 4;
    localparam int ST_FEQ  = 5;
    localparam int ST_DIFF = 6;
    localparam int ST_MUL  = 7;
    localparam int ST_OUT  = 8;

    typedef logic signed [31:0] q30_t;
    typedef q30_t [NDIR-1:0] q30_vec_t;

    typedef enum logic [1:0] {
        KIND_WALL  = 2'd0,
        KIND_LID   = 2'd1,
        KIND_FLUID = 2'd2
    } kind_t;

    localparam logic [1:0] REG_RELAX = 2'd0;
    localparam logic [1:0] REG_LID_X = 2'd1;
    localparam logic [1:0] REG_LID_Y = 2'd2;

    localparam logic [30:0] RELAX_RESET = 31'd1073741824;
    localparam logic [31:0] LID_X_RESET = 32'd85899346;
    localparam logic [31:0] LID_Y_RESET = 32'd0;

    // Reciprocal multipliers for exact constant division
    localparam logic [17:0] DIV9_HI_MUL = 18'd233017;   // >> 21
    localparam logic [21:0] DIV9_LO_MUL = 22'd3728271;  // >> 25
    localparam logic [17:0] DIV3_HI_MUL = 18'd174763;   // >> 19
    localparam logic [19:0] DIV3_LO_MUL = 20'd699051;   // >> 21

    function automatic q30_t sat_q30(input logic signed [63:0] v);
        q30_t r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // floor(v*v / 2^30)
    function automatic logic [34:0] sq_q30(input logic signed [32:0] v);
        logic [32:0] m;
        logic [65:0] p;
        m = v[32] ? 33'(-v) : 33'(v);
        p = {33'b0, m} * {33'b0, m};
        return p[64:30];
    endfunction

    // c_i . (x, y)
    function automatic logic signed [33:0] dir_proj(input int i,
                                                    input logic signed [31:0] x,
                                                    input logic signed [31:0] y);
        logic signed [33:0] xe;
        logic signed [33:0] ye;
        logic signed [33:0] r;
        xe = 34'(x);
        ye = 34'(y);
        case (i)
            1:       r = ye;
            2:       r = xe + ye;
            3:       r = xe;
            4:       r = xe - ye;
            5:       r = -ye;
            6:       r = -xe - ye;
            7:       r = -xe;
            8:       r = ye - xe;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic int opp_dir(input int i);
        int r;
        case (i)
            1:       r = 5;
            2:       r = 6;
            3:       r = 7;
            4:       r = 8;
            5:       r = 1;
            6:       r = 2;
            7:       r = 3;
            8:       r = 4;
            default: r = 0;
        endcase
        return r;
    endfunction

    function automatic logic is_diag(input int i);
        return (i == 2) || (i == 4) || (i == 6) || (i == 8);
    endfunction

    // log2 of the weight numerator (16, 4 or 1)
    function automatic int wshift(input int i);
        int r;
        if (i == 0)
            r = 4;
        else if (is_diag(i))
            r = 0;
        else
            r = 2;
        return r;
    endfunction

endpackage

// ----- rtl/d2q9_lattice_cell_collide.sv -----
`timescale 1ns / 1ps
// D2Q9 lattice Boltzmann cell collision, one cell per item. The block takes
// one item per clock while the pipeline is free to advance, and its
// results pass the nine-register pipeline (input, moments, squares,
// bracket, two reciprocal-multiply stages for the divide by 72, difference,
// omega multiply, saturating add). Stages hold under out_stall and empty slots
// collapse, so in_stall rises only once every stage holds a waiting item.
// Wall cells (and unused kind 3) reflect each moving distribution; moving-lid
// cells subtract 6*w*(c.u_lid) first; fluid cells relax toward equilibrium
// with omega from relax_rate and report density and momenta, which read zero
// for other cells. Registers sit on the APB port at 0x0 (relax_rate),
// 0x4 (lid_speed_x) and 0x8 (lid_speed_y); write them only while idle.
`include "assert_macros.svh"
module d2q9_lattice_cell_collide (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cell_kind,
    input  logic signed [31:0] pdf_rest,
    input  logic signed [31:0] pdf_north,
    input  logic signed [31:0] pdf_northeast,
    input  logic signed [31:0] pdf_east,
    input  logic signed [31:0] pdf_southeast,
    input  logic signed [31:0] pdf_south,
    input  logic signed [31:0] pdf_southwest,
    input  logic signed [31:0] pdf_west,
    input  logic signed [31:0] pdf_northwest,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_rest,
    output logic signed [31:0] new_north,
    output logic signed [31:0] new_northeast,
    output logic signed [31:0] new_east,
    output logic signed [31:0] new_southeast,
    output logic signed [31:0] new_south,
    output logic signed [31:0] new_southwest,
    output logic signed [31:0] new_west,
    output logic signed [31:0] new_northwest,
    output logic signed [31:0] cell_density,
    output logic signed [31:0] momentum_x,
    output logic signed [31:0] momentum_y
);
    import d2q_pkg::*;

    // Configuration registers
    logic [30:0] relax_rate_reg;
    logic [31:0] lid_x_reg;
    logic [31:0] lid_y_reg;
    logic        cfg_wr;

    // Pipeline control: adv[k] loads stage k, adv[NSTAGE] is the sink
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_next;
    logic [NSTAGE:0]   adv;

    // Carried payload
    logic [1:0] kind_reg [NSTAGE];
    q30_vec_t   f_reg    [ST_FEQ+1];
    q30_t       rho_reg  [NSTAGE];
    q30_t       jx_reg   [NSTAGE];
    q30_t       jy_reg   [NSTAGE];
    q30_vec_t   wall_reg [NSTAGE];

    q30_vec_t    f_in;
    q30_t        rho_s2, jx_s2, jy_s2;
    logic [34:0] sxx_s2, syy_s2, spp_s2, smm_s2;
    q30_vec_t    feq_s5;
    q30_vec_t    wall_s3;
    q30_vec_t    fluid_s8;
    q30_vec_t    res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_rate_reg <= RELAX_RESET;
            lid_x_reg      <= LID_X_RESET;
            lid_y_reg      <= LID_Y_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_RELAX: relax_rate_reg <= pwdata[30:0];
                REG_LID_X: lid_x_reg      <= pwdata;
                REG_LID_Y: lid_y_reg      <= pwdata;
                default:   ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_RELAX: prdata = {1'b0, relax_rate_reg};
            REG_LID_X: prdata = lid_x_reg;
            REG_LID_Y: prdata = lid_y_reg;
            default:   prdata = '0;
        endcase
    end

    // A stage advances when it is empty or the stage after it advances
    always_comb
    begin
        adv[NSTAGE] = !out_stall;
        for (int k = NSTAGE - 1; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
        v_next[0] = adv[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NSTAGE; k++)
            v_next[k] = adv[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_stall  = !adv[0];
    assign out_valid = v_reg[NSTAGE-1];

    assign f_in[0] = pdf_rest;
    assign f_in[1] = pdf_north;
    assign f_in[2] = pdf_northeast;
    assign f_in[3] = pdf_east;
    assign f_in[4] = pdf_southeast;
    assign f_in[5] = pdf_south;
    assign f_in[6] = pdf_southwest;
    assign f_in[7] = pdf_west;
    assign f_in[8] = pdf_northwest;

    // Advance payload alongside the valid bits
    always_ff @(posedge clk)
    begin
        if (adv[ST_IN])
        begin
            kind_reg[ST_IN] <= cell_kind;
            f_reg[ST_IN]    <= f_in;
        end
        for (int k = 1; k < NSTAGE; k++)
        begin
            if (adv[k])
                kind_reg[k] <= kind_reg[k-1];
        end
        for (int k = 1; k <= ST_FEQ; k++)
        begin
            if (adv[k])
                f_reg[k] <= f_reg[k-1];
        end
        if (adv[ST_B2])
        begin
            rho_reg[ST_B2] <= rho_s2;
            jx_reg[ST_B2]  <= jx_s2;
            jy_reg[ST_B2]  <= jy_s2;
        end
        for (int k = ST_B2 + 1; k < NSTAGE; k++)
        begin
            if (adv[k])
            begin
                rho_reg[k] <= rho_reg[k-1];
                jx_reg[k]  <= jx_reg[k-1];
                jy_reg[k]  <= jy_reg[k-1];
            end
        end
        // The bounce unit already registers stage 3; carry it on from stage 4
        if (adv[ST_DA])
            wall_reg[ST_DA] <= wall_s3;
        for (int k = ST_DA + 1; k < NSTAGE; k++)
        begin
            if (adv[k])
                wall_reg[k] <= wall_reg[k-1];
        end
    end

    d2q_moments u_moments (
        .clk     (clk),
        .adv     (adv[NSTAGE-1:0]),
        .f_in    (f_reg[ST_IN]),
        .rho_out (rho_s2),
        .jx_out  (jx_s2),
        .jy_out  (jy_s2),
        .sxx_out (sxx_s2),
        .syy_out (syy_s2),
        .spp_out (spp_s2),
        .smm_out (smm_s2)
    );

    d2q_equilibrium u_equilibrium (
        .clk     (clk),
        .adv     (adv[NSTAGE-1:0]),
        .rho_in  (rho_s2),
        .jx_in   (jx_s2),
        .jy_in   (jy_s2),
        .sxx_in  (sxx_s2),
        .syy_in  (syy_s2),
        .spp_in  (spp_s2),
        .smm_in  (smm_s2),
        .feq_out (feq_s5)
    );

    // Lid terms depend on configuration only; the reflection lands at stage 3
    d2q_bounce u_bounce (
        .clk     (clk),
        .adv     (adv[NSTAGE-1:0]),
        .lid_x   ($signed(lid_x_reg)),
        .lid_y   ($signed(lid_y_reg)),
        .kind_in (kind_reg[ST_SQ]),
        .f_in    (f_reg[ST_SQ]),
        .pdf_out (wall_s3)
    );

    d2q_relax u_relax (
        .clk     (clk),
        .adv     (adv[NSTAGE-1:0]),
        .omega   (relax_rate_reg),
        .feq_in  (feq_s5),
        .f_in    (f_reg[ST_FEQ]),
        .pdf_out (fluid_s8)
    );

    // Select the path of the cell kind; non-fluid cells report zero moments
    always_comb
    begin
        if (kind_reg[ST_OUT] == KIND_FLUID)
        begin
            res          = fluid_s8;
            cell_density = rho_reg[ST_OUT];
            momentum_x   = jx_reg[ST_OUT];
            momentum_y   = jy_reg[ST_OUT];
        end
        else
        begin
            res          = wall_reg[ST_OUT];
            cell_density = '0;
            momentum_x   = '0;
            momentum_y   = '0;
        end
    end

    assign new_rest      = res[0];
    assign new_north     = res[1];
    assign new_northeast = res[2];
    assign new_east      = res[3];
    assign new_southeast = res[4];
    assign new_south     = res[5];
    assign new_southwest = res[6];
    assign new_west      = res[7];
    assign new_northwest = res[8];

    `ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, v_reg[ST_IN], "accepted item lost at entry")
    `ASSERT_IMPL(a_stall_full, in_stall, &v_reg, "input stalled with an empty stage")
    `ASSERT_NEXT(a_mid_hold, v_reg[ST_B2] && !adv[ST_DA], v_reg[ST_B2], "held item dropped")

endmodule

// ----- rtl/d2q_moments.sv -----
`timescale 1ns / 1ps
module d2q_moments (
    input  logic                           clk,
    input  logic [d2q_pkg::NSTAGE-1:0]     adv,
    input  d2q_pkg::q30_vec_t              f_in,
    output d2q_pkg::q30_t                  rho_out,
    output d2q_pkg::q30_t                  jx_out,
    output d2q_pkg::q30_t                  jy_out,
    output logic [34:0]                    sxx_out,
    output logic [34:0]                    syy_out,
    output logic [34:0]                    spp_out,
    output logic [34:0]                    smm_out
);
    import d2q_pkg::*;

    logic signed [35:0] rho_sum;
    logic signed [35:0] jx_sum;
    logic signed [35:0] jy_sum;
    q30_t rho1_reg, jx1_reg, jy1_reg;
    q30_t rho2_reg, jx2_reg, jy2_reg;
    logic [34:0] sxx_reg, syy_reg, spp_reg, smm_reg;

    always_comb
    begin
        rho_sum = '0;
        for (int i = 0; i < NDIR; i++)
            rho_sum = rho_sum + 36'($signed(f_in[i]));
        jx_sum = 36'($signed(f_in[2])) + 36'($signed(f_in[3])) + 36'($signed(f_in[4]))
               - 36'($signed(f_in[6])) - 36'($signed(f_in[7])) - 36'($signed(f_in[8]));
        jy_sum = 36'($signed(f_in[1])) + 36'($signed(f_in[2])) + 36'($signed(f_in[8]))
               - 36'($signed(f_in[4])) - 36'($signed(f_in[5])) - 36'($signed(f_in[6]));
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_MOM])
        begin
            rho1_reg <= sat_q30(64'(rho_sum));
            jx1_reg  <= sat_q30(64'(jx_sum));
            jy1_reg  <= sat_q30(64'(jy_sum));
        end
        if (adv[ST_SQ])
        begin
            rho2_reg <= rho1_reg;
            jx2_reg  <= jx1_reg;
            jy2_reg  <= jy1_reg;
            sxx_reg  <= sq_q30(33'(jx1_reg));
            syy_reg  <= sq_q30(33'(jy1_reg));
            spp_reg  <= sq_q30(33'(jx1_reg) + 33'(jy1_reg));
            smm_reg  <= sq_q30(33'(jx1_reg) - 33'(jy1_reg));
        end
    end

    assign rho_out = rho2_reg;
    assign jx_out  = jx2_reg;
    assign jy_out  = jy2_reg;
    assign sxx_out = sxx_reg;
    assign syy_out = syy_reg;
    assign spp_out = spp_reg;
    assign smm_out = smm_reg;

endmodule

// ----- rtl/d2q_equilibrium.sv -----
`timescale 1ns / 1ps
module d2q_equilibrium (
    input  logic                           clk,
    input  logic [d2q_pkg::NSTAGE-1:0]     adv,
    input  d2q_pkg::q30_t                  rho_in,
    input  d2q_pkg::q30_t                  jx_in,
    input  d2q_pkg::q30_t                  jy_in,
    input  logic [34:0]                    sxx_in,
    input  logic [34:0]                    syy_in,
    input  logic [34:0]                    spp_in,
    input  logic [34:0]                    smm_in,
    output d2q_pkg::q30_vec_t              feq_out
);
    import d2q_pkg::*;

    localparam logic signed [43:0] M_LO = -44'sd19327352832;
    localparam logic signed [43:0] M_HI = 44'sd19327352831;

    logic [35:0] mo_next [NDIR];
    logic [35:0] mo_reg  [NDIR];
    logic [13:0] qa_next [NDIR];
    logic [13:0] qa_reg  [NDIR];
    logic [21:0] x2_next [NDIR];
    logic [21:0] x2_reg  [NDIR];
    q30_vec_t    feq_next;
    q30_vec_t    feq_reg;

    // 72 * feq = (weight numerator) * B2, offset to a non-negative dividend and clamped
    always_comb
    begin
        logic signed [43:0] cu;
        logic [34:0]        sq;
        logic signed [43:0] usq;
        logic signed [43:0] b2;
        logic signed [43:0] m;
        usq = 44'(sxx_in) + 44'(syy_in);
        for (int i = 0; i < NDIR; i++)
        begin
            cu = 44'(dir_proj(i, jx_in, jy_in));
            case (i)
                1, 5:    sq = syy_in;
                2, 6:    sq = spp_in;
                3, 7:    sq = sxx_in;
                4, 8:    sq = smm_in;
                default: sq = '0;
            endcase
            b2 = (44'(rho_in) <<< 1) + (cu <<< 2) + (cu <<< 1)
               + (44'(sq) <<< 3) + 44'(sq) - (usq <<< 1) - usq;
            m = ((b2 <<< wshift(i)) + 44'sd36) >>> 3;
            if (m < M_LO)
                m = M_LO;
            else if (m > M_HI)
                m = M_HI;
            mo_next[i] = 36'(m - M_LO);
        end
    end

    // High half divided by 9, remainder joined to the low half
    always_comb
    begin
        logic [35:0] pa;
        logic [17:0] a;
        logic [17:0] rem;
        for (int i = 0; i < NDIR; i++)
        begin
            a          = mo_reg[i][35:18];
            pa         = 36'(a) * 36'(DIV9_HI_MUL);
            qa_next[i] = pa[34:21];
            rem        = a - 18'({4'b0, pa[34:21]} * 18'd9);
            x2_next[i] = {rem[3:0], mo_reg[i][17:0]};
        end
    end

    // Quotient minus 2^31 is the quotient with its top bit flipped
    always_comb
    begin
        logic [43:0] pb;
        for (int i = 0; i < NDIR; i++)
        begin
            pb          = 44'(x2_reg[i]) * 44'(DIV9_LO_MUL);
            feq_next[i] = {~qa_reg[i][13], qa_reg[i][12:0], pb[42:25]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NDIR; i++)
        begin
            if (adv[ST_B2])
                mo_reg[i] <= mo_next[i];
            if (adv[ST_DA])
            begin
                qa_reg[i] <= qa_next[i];
                x2_reg[i] <= x2_next[i];
            end
        end
        if (adv[ST_FEQ])
            feq_reg <= feq_next;
    end

    assign feq_out = feq_reg;

endmodule

// ----- rtl/d2q_bounce.sv -----
`timescale 1ns / 1ps
module d2q_bounce (
    input  logic                           clk,
    input  logic [d2q_pkg::NSTAGE-1:0]     adv,
    input  logic signed [31:0]             lid_x,
    input  logic signed [31:0]             lid_y,
    input  logic [1:0]                     kind_in,
    input  d2q_pkg::q30_vec_t              f_in,
    output d2q_pkg::q30_vec_t              pdf_out
);
    import d2q_pkg::*;

    localparam logic signed [36:0] Y_OFS = 37'sd25769803776;
    localparam logic signed [34:0] Q_OFS = 35'sd8589934592;

    logic [34:0] yo_next [NDIR];
    logic [34:0] yo_reg  [NDIR];
    logic [15:0] qa_next [NDIR];
    logic [15:0] qa_reg  [NDIR];
    logic [19:0] x2_next [NDIR];
    logic [19:0] x2_reg  [NDIR];
    q30_vec_t    pdf_next;
    q30_vec_t    pdf_reg;

    // Correction round(k*dot/6) = floor(floor((k*dot+3)/2)/3), offset positive
    always_comb
    begin
        logic signed [36:0] dot;
        logic signed [36:0] x;
        for (int i = 0; i < NDIR; i++)
        begin
            dot = 37'(dir_proj(i, lid_x, lid_y));
            x   = is_diag(i) ? dot + 37'sd3 : (dot <<< 2) + 37'sd3;
            yo_next[i] = 35'((x >>> 1) + Y_OFS);
        end
    end

    always_comb
    begin
        logic [34:0] pa;
        logic [16:0] a;
        logic [17:0] rem;
        for (int i = 0; i < NDIR; i++)
        begin
            a          = yo_reg[i][34:18];
            pa         = 35'(a) * 35'(DIV3_HI_MUL);
            qa_next[i] = pa[34:19];
            rem        = 18'(a) - 18'({2'b0, pa[34:19]} * 18'd3);
            x2_next[i] = {rem[1:0], yo_reg[i][17:0]};
        end
    end

    // Subtract the lid term, saturate, reflect into the opposite direction
    always_comb
    begin
        logic [39:0]        pb;
        logic signed [34:0] corr;
        q30_vec_t           c;
        for (int i = 0; i < NDIR; i++)
        begin
            pb   = 40'(x2_reg[i]) * 40'(DIV3_LO_MUL);
            corr = $signed({1'b0, qa_reg[i], pb[38:21]}) - Q_OFS;
            if ((kind_in != KIND_LID) || (i == 0))
                corr = '0;
            c[i] = sat_q30(64'($signed(f_in[i])) - 64'(corr));
        end
        for (int i = 0; i < NDIR; i++)
            pdf_next[i] = c[opp_dir(i)];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NDIR; i++)
        begin
            if (adv[ST_MOM])
                yo_reg[i] <= yo_next[i];
            if (adv[ST_SQ])
            begin
                qa_reg[i] <= qa_next[i];
                x2_reg[i] <= x2_next[i];
            end
        end
        if (adv[ST_B2])
            pdf_reg <= pdf_next;
    end

    assign pdf_out = pdf_reg;

endmodule

// ----- rtl/d2q_relax.sv -----
`timescale 1ns / 1ps
module d2q_relax (
    input  logic                           clk,
    input  logic [d2q_pkg::NSTAGE-1:0]     adv,
    input  logic [30:0]                    omega,
    input  d2q_pkg::q30_vec_t              feq_in,
    input  d2q_pkg::q30_vec_t              f_in,
    output d2q_pkg::q30_vec_t              pdf_out
);
    import d2q_pkg::*;

    logic signed [32:0] d_reg    [NDIR];
    logic signed [64:0] prod_reg [NDIR];
    q30_vec_t           f6_reg;
    q30_vec_t           f7_reg;
    q30_vec_t           pdf_next;
    q30_vec_t           pdf_reg;

    // f + round(omega * (feq - f) / 2^30), saturated
    always_comb
    begin
        logic signed [64:0] r;
        for (int i = 0; i < NDIR; i++)
        begin
            r = (prod_reg[i] + 65'sd536870912) >>> 30;
            pdf_next[i] = sat_q30(64'($signed(f7_reg[i])) + 64'(r));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_DIFF])
        begin
            f6_reg <= f_in;
            for (int i = 0; i < NDIR; i++)
                d_reg[i] <= 33'($signed(feq_in[i])) - 33'($signed(f_in[i]));
        end
        if (adv[ST_MUL])
        begin
            f7_reg <= f6_reg;
            for (int i = 0; i < NDIR; i++)
                prod_reg[i] <= 65'($signed({1'b0, omega})) * 65'(d_reg[i]);
        end
        if (adv[ST_OUT])
            pdf_reg <= pdf_next;
    end

    assign pdf_out = pdf_reg;

endmodule

// ----- tb/d2q9_lattice_cell_collide_tb.sv -----
`timescale 1ns / 1ps
module d2q9_lattice_cell_collide_tb;
    import d2q_pkg::*;

    // Lattice geometry: direction vectors and weight numerators (over 36).
    localparam int DX[9] = '{0, 0, 1, 1, 1, 0, -1, -1, -1};
    localparam int DY[9] = '{0, 1, 1, 0, -1, -1, -1, 0, 1};
    localparam longint WNUM[9] = '{16, 4, 1, 4, 1, 4, 1, 4, 1};
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int PIPE_DRAIN = 12;

    // One result item: nine updated distributions, then density, jx, jy.
    typedef logic [11:0][31:0] cell_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] cell_kind = '0;
    q30_vec_t pdf = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    q30_vec_t newv;
    q30_t cell_density, momentum_x, momentum_y;

    // Shadow copy of the configuration registers.
    longint omega_q30 = longint'(RELAX_RESET);
    longint lid_x = longint'($signed(LID_X_RESET));
    longint lid_y = longint'($signed(LID_Y_RESET));

    cell_out_t expected_cells[$];
    int errors = 0;
    int quiet_cycles = 0;
    bit no_gaps = 1'b0;

    d2q9_lattice_cell_collide u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .cell_kind(cell_kind),
        .pdf_rest(pdf[0]), .pdf_north(pdf[1]), .pdf_northeast(pdf[2]),
        .pdf_east(pdf[3]), .pdf_southeast(pdf[4]), .pdf_south(pdf[5]),
        .pdf_southwest(pdf[6]), .pdf_west(pdf[7]), .pdf_northwest(pdf[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_rest(newv[0]), .new_north(newv[1]), .new_northeast(newv[2]),
        .new_east(newv[3]), .new_southeast(newv[4]), .new_south(newv[5]),
        .new_southwest(newv[6]), .new_west(newv[7]), .new_northwest(newv[8]),
        .cell_density(cell_density), .momentum_x(momentum_x),
        .momentum_y(momentum_y)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clamp_q30(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Round to nearest, ties toward plus infinity; den is positive and even.
    function automatic longint round_div(longint n, longint den);
        longint q;
        q = (n + den / 2) / den;
        if (((n + den / 2) % den) != 0 && (n + den / 2) < 0)
            q = q - 1;
        return q;
    endfunction

    // floor(v*v / 2^30), computed wide so that |v| up to 2^32 fits.
    function automatic longint square_q30(longint v);
        logic [65:0] m;
        logic [65:0] p;
        m = (v < 0) ? 66'(-v) : 66'(v);
        p = m * m;
        return longint'(p[65:30]);
    endfunction

    // Predict the collided cell from its kind and pulled distributions.
    function automatic cell_out_t collide_cell(logic [1:0] kind, q30_vec_t f_in);
        longint f[9];
        longint g[9];
        longint c[9];
        longint rho, jx, jy, usq, cu, b2, feq, dot, corr;
        cell_out_t r;
        rho = 0;
        jx = 0;
        jy = 0;
        for (int i = 0; i < 9; i++)
            f[i] = longint'(f_in[i]);
        if (kind == KIND_FLUID)
        begin
            for (int i = 0; i < 9; i++)
            begin
                rho += f[i];
                jx += DX[i] * f[i];
                jy += DY[i] * f[i];
            end
            rho = clamp_q30(rho);
            jx = clamp_q30(jx);
            jy = clamp_q30(jy);
            usq = square_q30(jx) + square_q30(jy);
            for (int i = 0; i < 9; i++)
            begin
                cu = DX[i] * jx + DY[i] * jy;
                b2 = 2 * rho + 6 * cu + 9 * square_q30(cu) - 3 * usq;
                feq = clamp_q30(round_div(WNUM[i] * b2, 72));
                g[i] = clamp_q30(f[i] + round_div(omega_q30 * (feq - f[i]), ONE_Q30));
            end
        end
        else
        begin
            // Walls (and the unused kind) reflect; lids remove 6*w*(c.u) first.
            c[0] = f[0];
            for (int i = 1; i < 9; i++)
            begin
                corr = 0;
                if (kind == KIND_LID)
                begin
                    dot = DX[i] * lid_x + DY[i] * lid_y;
                    corr = (DX[i] != 0 && DY[i] != 0) ? round_div(dot, 6)
                                                       : round_div(4 * dot, 6);
                end
                c[i] = clamp_q30(f[i] - corr);
            end
            g[0] = c[0];
            for (int i = 1; i < 9; i++)
                g[i] = c[((i + 3) % 8) + 1];
        end
        for (int i = 0; i < 9; i++)
            r[i] = 32'(g[i]);
        r[9] = 32'(rho);
        r[10] = 32'(jx);
        r[11] = 32'(jy);
        return r;
    endfunction

    // Random distribution: mostly physical magnitudes, some extremes, some raw.
    function automatic q30_t rand_pdf();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return q30_t'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000
                                  + 32'sh0400_0000;
            5: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
            6: return q30_t'($urandom_range(0, 255)) - 32'sd128;
            default: return q30_t'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_kind();
        case ($urandom_range(0, 9))
            0, 1: return KIND_WALL;
            2, 3: return KIND_LID;
            4: return KIND_UNUSED;
            default: return KIND_FLUID;
        endcase
    endfunction

    // Drive one cell, hold it until taken, and queue its expected result.
    task automatic send_cell(logic [1:0] kind, q30_vec_t f);
        while (!no_gaps && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cell_kind <= kind;
        pdf <= f;
        expected_cells.push_back(collide_cell(kind, f));
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random_cell();
        q30_vec_t f;
        for (int i = 0; i < 9; i++)
            f[i] = rand_pdf();
        send_cell(rand_kind(), f);
    endtask

    // Drop valid and wait for the pipeline to empty out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RELAX: omega_q30 = longint'(value[30:0]);
            REG_LID_X: lid_x = longint'($signed(value));
            default: lid_y = longint'($signed(value));
        endcase
    endtask

    task automatic set_config(logic [31:0] omega, logic [31:0] ux, logic [31:0] uy);
        wait_idle();
        write_reg(REG_RELAX, omega);
        write_reg(REG_LID_X, ux);
        write_reg(REG_LID_Y, uy);
    endtask

    // Directed: every kind at the reset settings, field extremes, saturation.
    task automatic test_directed();
        q30_vec_t f;
        logic [1:0] kinds[4] = '{KIND_WALL, KIND_LID, KIND_FLUID, KIND_UNUSED};
        foreach (kinds[k])
        begin
            for (int i = 0; i < 9; i++)
                f[i] = q30_t'(32'sd119304647 + i * 32'sd1000);
            send_cell(kinds[k], f);
            f = {9{32'sh7fffffff}};
            send_cell(kinds[k], f);
            f = {9{32'sh80000000}};
            send_cell(kinds[k], f);
            f = '0;
            send_cell(kinds[k], f);
            for (int i = 0; i < 9; i++)
                f[i] = (i % 2 != 0) ? 32'sh7fffffff : 32'sh80000000;
            send_cell(kinds[k], f);
        end
        // Lopsided flows saturate the momenta in each sign.
        f = '0;
        f[3] = 32'sh7fffffff;
        f[2] = 32'sh7fffffff;
        f[1] = 32'sh7fffffff;
        send_cell(KIND_FLUID, f);
        f = '0;
        f[7] = 32'sh7fffffff;
        f[6] = 32'sh7fffffff;
        f[5] = 32'sh7fffffff;
        send_cell(KIND_FLUID, f);
    endtask

    // Sweep settings, the extremes among them, with random cells per setting.
    task automatic test_config_sweep();
        logic [31:0] om_set[5] = '{32'd0, 32'h7fffffff, 32'h4000_0000, 32'h6000_0000, 32'd1};
        logic [31:0] ux_set[5] = '{32'h8000_0000, 32'h7fffffff, 32'd0, 32'd85899346, 32'd0};
        logic [31:0] uy_set[5] = '{32'h7fffffff, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0};
        for (int s = 0; s < 5; s++)
        begin
            set_config(om_set[s], ux_set[s], uy_set[s]);
            repeat (30) send_random_cell();
        end
        set_config($urandom, $urandom, $urandom);
        repeat (30) send_random_cell();
    endtask

    // Sender holds off until every expected result is back.
    task automatic test_drain_pause();
        repeat (10) send_random_cell();
        wait_idle();
        repeat (10) send_random_cell();
    endtask

    // Bulk random traffic with one long stretch of back-to-back traffic.
    task automatic test_random_stream();
        set_config(32'h5000_0000, $urandom, $urandom);
        repeat (100) send_random_cell();
        no_gaps = 1'b1;
        repeat (150) send_random_cell();
        no_gaps = 1'b0;
        repeat (130) send_random_cell();
    endtask

    // Receiver stall, with the same gap pattern as the sender.
    always @(posedge clk)
    begin
        out_stall <= !no_gaps && ($urandom_range(0, 99) < 38);
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge clk)
    begin
        cell_out_t exp_cell;
        cell_out_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {momentum_y, momentum_x, cell_density, newv};
            if (expected_cells.size() == 0)
            begin
                $display("%0t: unexpected item, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_cell = expected_cells.pop_front();
                for (int i = 0; i < 12; i++)
                    if (got[i] !== exp_cell[i])
                    begin
                        $display("%0t: field %0d expected %h actual %h",
                                 $time, i, exp_cell[i], got[i]);
                        errors++;
                    end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("d2q9_lattice_cell_collide verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_drain_pause();
        test_random_stream();
        wait_idle();
        if (errors == 0 && expected_cells.size() == 0)
            $display("d2q9_lattice_cell_collide verification clean");
        else
            $display("d2q9_lattice_cell_collide verification failed");
        $finish;
    end

endmodule
